### sv/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg: character LCD write sequencer package
// Field widths, action codes, step numbers, timing constants and the small
// lookup tables shared by the channel interfaces and the sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

  // field types
  typedef logic [2:0]  action_t;
  typedef logic [7:0]  byte_t;
  typedef logic [5:0]  step_t;
  typedef logic [14:0] wait_t;
  typedef logic [2:0]  init_idx_t;

  // action codes
  localparam action_t ACT_TICK = 3'd0;
  localparam action_t ACT_INIT = 3'd1;
  localparam action_t ACT_CMD  = 3'd2;
  localparam action_t ACT_CHAR = 3'd3;
  localparam action_t ACT_POS  = 3'd4;

  // sequencer step numbers
  localparam step_t STEP_IDLE       = 6'd0;
  localparam step_t STEP_EN_RISE    = 6'd2;
  localparam step_t STEP_HIGH_DATA  = 6'd3;
  localparam step_t STEP_EN_FALL_HI = 6'd4;
  localparam step_t STEP_EN_RISE_LO = 6'd5;
  localparam step_t STEP_LOW_DATA   = 6'd6;
  localparam step_t STEP_EN_FALL    = 6'd7;
  localparam step_t STEP_WAKE_FIRST = 6'd8;
  localparam step_t STEP_BYTE_DONE  = 6'd20;

  // bus layout and special command
  localparam int    NibbleOffset   = 0;
  localparam byte_t NIBBLE_MASK    = byte_t'(8'h0F << NibbleOffset);
  localparam byte_t DISPLAY_OFF    = 8'd8;
  localparam byte_t SET_DDRAM_FLAG = 8'h80;

  // hold times in microsecond ticks
  localparam wait_t HOLD_UNIT_8    = 15'd1;
  localparam wait_t HOLD_UNIT_4    = 15'd5;
  localparam wait_t HOLD_CHAR      = 15'd50;
  localparam wait_t HOLD_CMD       = 15'd100;
  localparam wait_t HOLD_OFF_8     = 15'd2000;
  localparam wait_t HOLD_OFF_4     = 15'd3000;
  localparam wait_t HOLD_POWER_UP  = 15'd20000;

  // init list length per bus width
  localparam init_idx_t INIT_LEN_8 = 3'd3;
  localparam init_idx_t INIT_LEN_4 = 3'd6;

  // phase within a wake-up nibble: 0 EN high, 1 data, 2 EN low
  typedef struct packed {
    logic [1:0] nib;
    logic [1:0] phase;
  } wake_pos_t;

  function automatic wake_pos_t wake_pos(input step_t s);
    wake_pos_t r;
    logic [3:0] d;
    d = 4'(s - STEP_WAKE_FIRST);
    case (d)
      4'd0:    r = '{nib: 2'd0, phase: 2'd0};
      4'd1:    r = '{nib: 2'd0, phase: 2'd1};
      4'd2:    r = '{nib: 2'd0, phase: 2'd2};
      4'd3:    r = '{nib: 2'd1, phase: 2'd0};
      4'd4:    r = '{nib: 2'd1, phase: 2'd1};
      4'd5:    r = '{nib: 2'd1, phase: 2'd2};
      4'd6:    r = '{nib: 2'd2, phase: 2'd0};
      4'd7:    r = '{nib: 2'd2, phase: 2'd1};
      4'd8:    r = '{nib: 2'd2, phase: 2'd2};
      4'd9:    r = '{nib: 2'd3, phase: 2'd0};
      4'd10:   r = '{nib: 2'd3, phase: 2'd1};
      default: r = '{nib: 2'd3, phase: 2'd2};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] wake_nibble(input logic [1:0] k);
    return (k == 2'd3) ? 4'd2 : 4'd3;
  endfunction

  function automatic wait_t wake_hold(input logic [1:0] k);
    wait_t h;
    case (k)
      2'd0:    h = 15'd5000;
      2'd1:    h = 15'd150;
      2'd2:    h = 15'd10;
      default: h = 15'd150;
    endcase
    return h;
  endfunction

  function automatic byte_t row_base(input logic [1:0] r);
    byte_t b;
    case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h10;
      default: b = 8'h50;
    endcase
    return b;
  endfunction

  // command i (from 0) of the init list
  function automatic byte_t init_item(input logic eight, input init_idx_t i,
                                      input byte_t cursor);
    byte_t b;
    if (eight) begin
      case (i)
        3'd0:    b = 8'h38;
        3'd1:    b = 8'h0C;
        default: b = 8'h01;
      endcase
    end else begin
      case (i)
        3'd0:    b = 8'h28;
        3'd1:    b = DISPLAY_OFF;
        3'd2:    b = 8'h01;
        3'd3:    b = 8'h06;
        3'd4:    b = 8'h02;
        default: b = cursor;
      endcase
    end
    return b;
  endfunction

  // replace the nibble at the offset, keep the other bus bits
  function automatic byte_t put_nibble(input byte_t bus, input logic [3:0] n);
    return (bus & ~NIBBLE_MASK) | (byte_t'({4'd0, n} << NibbleOffset) & NIBBLE_MASK);
  endfunction

endpackage

### sv/clws_ifs.sv
// ----------------------------------------------------------------------------
// clws channel interfaces
// Valid/ready channels for request transactions and pin result transactions.
// ----------------------------------------------------------------------------
interface clws_req_if;
  import clws_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  byte_t   value;
  byte_t   row;
  byte_t   col;

  modport source (output valid, action, value, row, col, input ready);
  modport sink   (input valid, action, value, row, col, output ready);
endinterface

interface clws_res_if;
  import clws_pkg::*;
  logic  valid;
  logic  ready;
  logic  rs_pin;
  logic  en_pin;
  byte_t data_bus;
  logic  busy_res;
  logic  rejected;

  modport source (output valid, rs_pin, en_pin, data_bus, busy_res, rejected,
                  input ready);
  modport sink   (input valid, rs_pin, en_pin, data_bus, busy_res, rejected,
                  output ready);
endinterface

### sv/char_lcd_write_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top: HD44780-style character LCD write sequencer
// Steps RS, EN and data pins through init, command, character and cursor
// position sequences on a 4-bit or 8-bit bus, paced by 1 us tick transactions.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_req    in         valid/ready    action, value, row, col
//  out_res   out        valid/ready    rs_pin, en_pin, data_bus, busy_res, rejected
//  cfg_*     in         write enable   eight_bit_bus
//
//  One transaction per cycle: the sequencer state and the output register
//  both load at the accepting edge, so each result is offered in the next cycle.
//  in_req.ready is high while the output register is empty or being drained,
//  so a stalled output holds one result and stops input only then.
//  rst_n (synchronous) clears the sequencer to idle with all pins low.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  clws_req_if.sink    in_req,
  clws_res_if.source  out_res,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import clws_pkg::*;

  // configuration and sequencer state
  logic      eight_r;
  step_t     step_r,   step_nxt;
  wait_t     wait_r,   wait_nxt;
  byte_t     held_r,   held_nxt;
  init_idx_t idx_r,    idx_nxt;
  byte_t     cursor_r, cursor_nxt;
  logic      rs_r,     rs_nxt;
  logic      en_r,     en_nxt;
  byte_t     bus_r,    bus_nxt;

  // output register
  logic      out_valid_r;
  logic      out_rs_r, out_en_r, out_busy_r, out_rej_r;
  byte_t     out_bus_r;

  logic      accept;
  logic      busy;
  logic      do_step;
  logic      rejected;
  wait_t     unit_hold;
  wait_t     wait_dec;
  wake_pos_t wp;
  init_idx_t init_len;
  byte_t     pos_row;
  byte_t     pos_cmd;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign busy         = (step_r != STEP_IDLE);
  assign unit_hold    = eight_r ? HOLD_UNIT_8 : HOLD_UNIT_4;
  assign init_len     = eight_r ? INIT_LEN_8 : INIT_LEN_4;
  assign wait_dec     = (wait_r != '0) ? wait_r - 15'd1 : wait_r;
  assign wp           = wake_pos(step_r);
  assign pos_row      = in_req.row + {4'd0, in_req.col[7:4]};
  assign pos_cmd      = (row_base(pos_row[1:0]) + {4'd0, in_req.col[3:0]}) | SET_DDRAM_FLAG;

  // next state: request decode, tick countdown, then one sequencer step
  always_comb begin
    step_nxt   = step_r;
    wait_nxt   = wait_r;
    held_nxt   = held_r;
    idx_nxt    = idx_r;
    cursor_nxt = cursor_r;
    rs_nxt     = rs_r;
    en_nxt     = en_r;
    bus_nxt    = bus_r;
    rejected   = 1'b0;
    do_step    = 1'b0;

    case (in_req.action) inside
      ACT_TICK: begin
        if (busy) begin
          wait_nxt = wait_dec;
          do_step  = (wait_dec == '0);
        end
      end
      ACT_INIT, ACT_CMD, ACT_CHAR, ACT_POS: begin
        if (busy) begin
          rejected = 1'b1;
        end else if (in_req.action == ACT_INIT) begin
          cursor_nxt = in_req.value;
          idx_nxt    = 3'd1;
          wait_nxt   = HOLD_POWER_UP;
          step_nxt   = eight_r ? STEP_BYTE_DONE : STEP_WAKE_FIRST;
        end else if (in_req.action == ACT_POS && pos_row >= 8'd4) begin
          rejected = 1'b1;
        end else begin
          held_nxt = (in_req.action == ACT_POS) ? pos_cmd : in_req.value;
          rs_nxt   = (in_req.action == ACT_CHAR);
          wait_nxt = unit_hold;
          step_nxt = STEP_EN_RISE;
        end
      end
      default: ;
    endcase

    // one pin step once the hold has run out
    if (do_step) begin
      if (step_r >= STEP_WAKE_FIRST && step_r < STEP_BYTE_DONE) begin
        case (wp.phase)
          2'd0: begin
            en_nxt   = 1'b1;
            rs_nxt   = 1'b0;
            wait_nxt = HOLD_UNIT_4;
          end
          2'd1: begin
            bus_nxt  = put_nibble(bus_r, wake_nibble(wp.nib));
            wait_nxt = HOLD_UNIT_4;
          end
          default: begin
            en_nxt   = 1'b0;
            wait_nxt = wake_hold(wp.nib);
          end
        endcase
        step_nxt = step_r + 6'd1;
      end else begin
        unique case (step_r)
          STEP_EN_RISE: begin
            en_nxt   = 1'b1;
            wait_nxt = unit_hold;
            step_nxt = STEP_HIGH_DATA;
          end
          STEP_HIGH_DATA: begin
            if (eight_r) begin
              bus_nxt  = held_r;
              step_nxt = STEP_EN_FALL;
            end else begin
              bus_nxt  = put_nibble(bus_r, held_r[7:4]);
              step_nxt = STEP_EN_FALL_HI;
            end
            wait_nxt = unit_hold;
          end
          STEP_EN_FALL_HI: begin
            en_nxt   = 1'b0;
            wait_nxt = unit_hold;
            step_nxt = STEP_EN_RISE_LO;
          end
          STEP_EN_RISE_LO: begin
            en_nxt   = 1'b1;
            wait_nxt = unit_hold;
            step_nxt = STEP_LOW_DATA;
          end
          STEP_LOW_DATA: begin
            bus_nxt  = put_nibble(bus_r, held_r[3:0]);
            wait_nxt = unit_hold;
            step_nxt = STEP_EN_FALL;
          end
          STEP_EN_FALL: begin
            en_nxt = 1'b0;
            if (rs_r)
              wait_nxt = HOLD_CHAR;
            else if (held_r == DISPLAY_OFF)
              wait_nxt = eight_r ? HOLD_OFF_8 : HOLD_OFF_4;
            else
              wait_nxt = HOLD_CMD;
            step_nxt = STEP_BYTE_DONE;
          end
          STEP_BYTE_DONE: begin
            if (idx_r != '0 && idx_r <= init_len) begin
              held_nxt = init_item(eight_r, idx_r - 3'd1, cursor_r);
              idx_nxt  = idx_r + 3'd1;
              rs_nxt   = 1'b0;
              wait_nxt = unit_hold;
              step_nxt = STEP_EN_RISE;
            end else begin
              step_nxt = STEP_IDLE;
              wait_nxt = '0;
              idx_nxt  = '0;
            end
          end
          default: begin
            step_nxt = STEP_IDLE;
            wait_nxt = '0;
            idx_nxt  = '0;
          end
        endcase
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_r <= 1'b0;
    end else if (cfg_we) begin
      eight_r <= cfg_wdata;
    end
  end

  // sequencer state, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_IDLE;
      wait_r   <= '0;
      held_r   <= '0;
      idx_r    <= '0;
      cursor_r <= '0;
      rs_r     <= 1'b0;
      en_r     <= 1'b0;
      bus_r    <= '0;
    end else if (accept) begin
      step_r   <= step_nxt;
      wait_r   <= wait_nxt;
      held_r   <= held_nxt;
      idx_r    <= idx_nxt;
      cursor_r <= cursor_nxt;
      rs_r     <= rs_nxt;
      en_r     <= en_nxt;
      bus_r    <= bus_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      out_valid_r <= in_req.valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rs_r   <= rs_nxt;
      out_en_r   <= en_nxt;
      out_bus_r  <= bus_nxt;
      out_busy_r <= (step_nxt != STEP_IDLE);
      out_rej_r  <= rejected;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.rs_pin   = out_rs_r;
  assign out_res.en_pin   = out_en_r;
  assign out_res.data_bus = out_bus_r;
  assign out_res.busy_res = out_busy_r;
  assign out_res.rejected = out_rej_r;

endmodule

### sim/char_lcd_write_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top_test: self-checking bench for the LCD sequencer
// Drives request transactions (ticks, init, command, character, position)
// with random idle gaps and output stalls. Every transaction is predicted by
// a cycle-free model of the pin sequencer and each result is compared field
// by field. Both bus widths are run, including width changes mid-sequence.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top_test;
  import clws_pkg::*;

  // actions with no defined request
  localparam action_t ACT_NOP_FIRST = 3'd5;
  localparam action_t ACT_NOP_LAST  = 3'd7;

  localparam wait_t WAKE_STROBE   = 15'd5;
  localparam int    SETTLE_CYCLES = 4;
  localparam int    DRAIN_LIMIT   = 100000;
  localparam int    TIMEOUT_NS    = 200_000_000;
  localparam int    RANDOM_ITEMS  = 1850;

  typedef enum {PACE_RANDOM, PACE_SPARSE, PACE_NONE} pace_t;

  typedef struct packed {
    logic  rs;
    logic  en;
    byte_t bus;
    logic  busy;
    logic  rej;
  } pin_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  clws_req_if req_ch ();
  clws_res_if res_ch ();

  char_lcd_write_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  pace_t       pace = PACE_RANDOM;
  pin_result_t expected_pins[$];
  int          error_count     = 0;
  int          items_sent      = 0;
  int          results_checked = 0;
  int          rejects_seen    = 0;

  // predicted sequencer state
  logic      pred_eight;
  step_t     pred_step;
  wait_t     pred_wait;
  byte_t     pred_held;
  init_idx_t pred_init_idx;
  byte_t     pred_cursor;
  logic      pred_rs;
  logic      pred_en;
  byte_t     pred_bus;

  function automatic void reset_predictor();
    pred_eight    = 1'b0;
    pred_step     = STEP_IDLE;
    pred_wait     = '0;
    pred_held     = '0;
    pred_init_idx = '0;
    pred_cursor   = '0;
    pred_rs       = 1'b0;
    pred_en       = 1'b0;
    pred_bus      = '0;
  endfunction

  function automatic wait_t strobe_hold();
    return pred_eight ? HOLD_UNIT_8 : HOLD_UNIT_4;
  endfunction

  // bus with the nibble at the offset replaced
  function automatic byte_t with_nibble(byte_t bus, logic [3:0] n);
    byte_t mask;
    mask = byte_t'(8'h0F << NibbleOffset);
    return (bus & ~mask) | (byte_t'({4'b0000, n} << NibbleOffset) & mask);
  endfunction

  // hold after EN falls on each wake-up nibble
  function automatic wait_t wake_delay(int k);
    case (k)
      0:       return 15'd5000;
      1:       return 15'd150;
      2:       return 15'd10;
      default: return 15'd150;
    endcase
  endfunction

  // DDRAM base: bit 0 of the row adds 0x40, bit 1 adds 0x10
  function automatic byte_t cursor_base(logic [1:0] r);
    return (r[0] ? 8'h40 : 8'h00) | (r[1] ? 8'h10 : 8'h00);
  endfunction

  function automatic byte_t init_list_cmd(init_idx_t i);
    if (pred_eight) begin
      case (i)
        3'd0:    return 8'h38;
        3'd1:    return 8'h0C;
        default: return 8'h01;
      endcase
    end
    case (i)
      3'd0:    return 8'h28;
      3'd1:    return DISPLAY_OFF;
      3'd2:    return 8'h01;
      3'd3:    return 8'h06;
      3'd4:    return 8'h02;
      default: return pred_cursor;
    endcase
  endfunction

  function automatic void load_byte(byte_t b, logic rs);
    pred_held = b;
    pred_rs   = rs;
    pred_wait = strobe_hold();
    pred_step = STEP_EN_RISE;
  endfunction

  function automatic void enter_idle();
    pred_step     = STEP_IDLE;
    pred_wait     = '0;
    pred_init_idx = '0;
  endfunction

  // one step of the pin sequence, taken when the hold count runs out
  function automatic void advance_sequence();
    int    d;
    int    k;
    int    p;
    byte_t b;
    d = int'(pred_step) - int'(STEP_WAKE_FIRST);
    if (pred_step >= STEP_WAKE_FIRST && pred_step < STEP_BYTE_DONE) begin
      k = d / 3;
      p = d % 3;
      if (p == 0) begin
        pred_en   = 1'b1;
        pred_rs   = 1'b0;
        pred_wait = WAKE_STROBE;
      end else if (p == 1) begin
        pred_bus  = with_nibble(pred_bus, (k == 3) ? 4'd2 : 4'd3);
        pred_wait = WAKE_STROBE;
      end else begin
        pred_en   = 1'b0;
        pred_wait = wake_delay(k);
      end
      pred_step = pred_step + 6'd1;
      return;
    end
    case (pred_step)
      STEP_EN_RISE: begin
        pred_en   = 1'b1;
        pred_wait = strobe_hold();
        pred_step = STEP_HIGH_DATA;
      end
      STEP_HIGH_DATA: begin
        if (pred_eight) begin
          pred_bus  = pred_held;
          pred_step = STEP_EN_FALL;
        end else begin
          pred_bus  = with_nibble(pred_bus, pred_held[7:4]);
          pred_step = STEP_EN_FALL_HI;
        end
        pred_wait = strobe_hold();
      end
      STEP_EN_FALL_HI: begin
        pred_en   = 1'b0;
        pred_wait = strobe_hold();
        pred_step = STEP_EN_RISE_LO;
      end
      STEP_EN_RISE_LO: begin
        pred_en   = 1'b1;
        pred_wait = strobe_hold();
        pred_step = STEP_LOW_DATA;
      end
      STEP_LOW_DATA: begin
        pred_bus  = with_nibble(pred_bus, pred_held[3:0]);
        pred_wait = strobe_hold();
        pred_step = STEP_EN_FALL;
      end
      STEP_EN_FALL: begin
        pred_en = 1'b0;
        if (pred_rs)
          pred_wait = HOLD_CHAR;
        else if (pred_held == DISPLAY_OFF)
          pred_wait = pred_eight ? HOLD_OFF_8 : HOLD_OFF_4;
        else
          pred_wait = HOLD_CMD;
        pred_step = STEP_BYTE_DONE;
      end
      STEP_BYTE_DONE: begin
        if (pred_init_idx != 3'd0 &&
            pred_init_idx <= (pred_eight ? INIT_LEN_8 : INIT_LEN_4)) begin
          b = init_list_cmd(pred_init_idx - 3'd1);
          pred_init_idx = pred_init_idx + 3'd1;
          load_byte(b, 1'b0);
        end else begin
          enter_idle();
        end
      end
      default: enter_idle();
    endcase
  endfunction

  // expected pins after one accepted request transaction
  function automatic pin_result_t predict_pins(action_t act, byte_t val, byte_t row,
                                               byte_t col);
    pin_result_t res;
    logic        busy;
    logic        rej;
    byte_t       r_sum;
    rej  = 1'b0;
    busy = (pred_step != STEP_IDLE);
    if (act == ACT_TICK) begin
      if (busy) begin
        if (pred_wait != '0)
          pred_wait = pred_wait - 15'd1;
        if (pred_wait == '0)
          advance_sequence();
      end
    end else if (act <= ACT_POS) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        case (act)
          ACT_INIT: begin
            pred_cursor   = val;
            pred_init_idx = 3'd1;
            pred_wait     = HOLD_POWER_UP;
            pred_step     = pred_eight ? STEP_BYTE_DONE : STEP_WAKE_FIRST;
          end
          ACT_CMD:  load_byte(val, 1'b0);
          ACT_CHAR: load_byte(val, 1'b1);
          default: begin
            // column folds into rows by sixteen, row wraps at 8 bits
            r_sum = row + {4'b0000, col[7:4]};
            if (r_sum < 8'd4)
              load_byte((cursor_base(r_sum[1:0]) + {4'b0000, col[3:0]}) | SET_DDRAM_FLAG,
                        1'b0);
            else
              rej = 1'b1;
          end
        endcase
      end
    end
    res.rs   = pred_rs;
    res.en   = pred_en;
    res.bus  = pred_bus;
    res.busy = (pred_step != STEP_IDLE);
    res.rej  = rej;
    return res;
  endfunction

  function automatic int draw_pause();
    case (pace)
      PACE_NONE:   return 0;
      PACE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 17) : 0;
      default:     return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, expv, actv);
      error_count++;
    end
  endfunction

  // result side: random stalls, compare against the oldest prediction
  initial begin : result_monitor
    pin_result_t exp_r;
    int          stall;
    forever begin
      stall = draw_pause();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      results_checked++;
      if (res_ch.rejected === 1'b1)
        rejects_seen++;
      if (expected_pins.size() == 0) begin
        $error("result transaction with nothing expected: rs=%0b en=%0b bus=0x%02h",
               res_ch.rs_pin, res_ch.en_pin, res_ch.data_bus);
        error_count++;
      end else begin
        exp_r = expected_pins.pop_front();
        check_field("rs_pin", exp_r.rs, res_ch.rs_pin);
        check_field("en_pin", exp_r.en, res_ch.en_pin);
        check_field("data_bus", exp_r.bus, res_ch.data_bus);
        check_field("busy_res", exp_r.busy, res_ch.busy_res);
        check_field("rejected", exp_r.rej, res_ch.rejected);
      end
    end
  end

  // send one request transaction; valid stays high if the next follows at once
  task automatic send_request(action_t act, byte_t val, byte_t row, byte_t col);
    int gap;
    gap = draw_pause();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= val;
    req_ch.row    <= row;
    req_ch.col    <= col;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_pins.push_back(predict_pins(act, val, row, col));
    items_sent++;
  endtask

  task automatic send_tick();
    send_request(ACT_TICK, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
  endtask

  // a request that lands while the sequencer is busy
  task automatic send_busy_request();
    send_request(action_t'($urandom_range(ACT_INIT, ACT_POS)), byte_t'($urandom),
                 byte_t'($urandom), byte_t'($urandom));
  endtask

  task automatic run_to_idle(bit with_pokes);
    while (pred_step != STEP_IDLE) begin
      if (with_pokes && $urandom_range(0, 19) == 0)
        send_busy_request();
      else
        send_tick();
    end
  endtask

  // hold input until every expected result has arrived
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bus_width(logic eight);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= eight;
    @(posedge clk);
    cfg_we     <= 1'b0;
    pred_eight = eight;
  endtask

  task automatic place_cursor(byte_t row, byte_t col);
    send_request(ACT_POS, byte_t'($urandom), row, col);
    run_to_idle(1'b0);
  endtask

  // idle ticks, undefined actions and off-screen positions
  task automatic test_idle_requests();
    pace = PACE_RANDOM;
    send_tick();
    send_tick();
    send_request(ACT_NOP_FIRST, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_NOP_LAST, 8'h00, 8'h00, 8'h00);
    send_request(ACT_POS, 8'h00, 8'hFF, 8'hFF);
    send_request(ACT_POS, 8'h00, 8'h04, 8'h00);
    send_request(ACT_POS, 8'h00, 8'h00, 8'h40);
    send_request(ACT_POS, 8'h00, 8'd200, 8'h00);
  endtask

  // eight-bit init, with a request rejected during the power-up wait
  task automatic test_eight_bit_init();
    set_bus_width(1'b1);
    pace = PACE_SPARSE;
    send_request(ACT_INIT, 8'hFF, 8'h00, 8'h00);
    send_request(ACT_CMD, 8'h01, 8'h00, 8'h00);
    run_to_idle(1'b0);
  endtask

  // commands, characters and display-off on both widths
  task automatic test_byte_writes();
    logic eight;
    for (int w = 0; w < 2; w++) begin
      eight = (w == 0);
      set_bus_width(eight);
      pace = PACE_RANDOM;
      send_request(ACT_CMD, 8'h00, 8'h00, 8'h00);
      send_request(ACT_CHAR, 8'h41, 8'h00, 8'h00);
      run_to_idle(1'b0);
      send_request(ACT_CHAR, 8'hFF, 8'hFF, 8'hFF);
      run_to_idle(1'b0);
      pace = PACE_SPARSE;
      send_request(ACT_CMD, DISPLAY_OFF, 8'h00, 8'h00);
      send_request(ACT_POS, 8'h00, 8'h00, 8'h00);
      send_request(ACT_INIT, 8'h00, 8'h00, 8'h00);
      run_to_idle(1'b0);
    end
  endtask

  // first and last row bases, column fold and row wrap
  task automatic test_set_position();
    set_bus_width(1'b1);
    pace = PACE_RANDOM;
    place_cursor(8'd0, 8'h00);
    place_cursor(8'd3, 8'h0F);
    place_cursor(8'd0, 8'h3F);
    place_cursor(8'd255, 8'h10);
    place_cursor(8'd254, 8'h5F);
    place_cursor(8'd1, 8'h2A);
  endtask

  // four-bit wake-up nibbles and the full list ending in the cursor command
  task automatic test_four_bit_init();
    set_bus_width(1'b0);
    pace = PACE_SPARSE;
    send_request(ACT_INIT, 8'h0E, 8'h00, 8'h00);
    run_to_idle(1'b0);
  endtask

  // bus width changed while a byte or the init list is in progress
  task automatic test_width_change();
    set_bus_width(1'b0);
    pace = PACE_RANDOM;
    send_request(ACT_CMD, 8'hC3, 8'h00, 8'h00);
    repeat (12) send_tick();
    set_bus_width(1'b1);
    run_to_idle(1'b0);
    send_request(ACT_CHAR, 8'h3C, 8'h00, 8'h00);
    repeat (2) send_tick();
    set_bus_width(1'b0);
    run_to_idle(1'b0);
    // four-bit list past the eight-bit length: switching ends the list
    pace = PACE_SPARSE;
    send_request(ACT_INIT, 8'h0C, 8'h00, 8'h00);
    while (pred_init_idx < 3'd5) send_tick();
    set_bus_width(1'b1);
    run_to_idle(1'b0);
  endtask

  // random sequences: mostly well-formed requests run to idle, plus noise
  task automatic test_random_traffic();
    int    start;
    int    kind;
    int    fold;
    int    up;
    int    n;
    byte_t row_v;
    byte_t col_v;
    action_t act;
    for (int ph = 0; ph < 4; ph++) begin
      set_bus_width(ph % 2 == 0);
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / 4) begin
        pace = pace_t'($urandom_range(0, 2));
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          case ($urandom_range(0, 2))
            0: send_request(ACT_CMD, byte_t'($urandom), byte_t'($urandom),
                            byte_t'($urandom));
            1: send_request(ACT_CHAR, byte_t'($urandom), byte_t'($urandom),
                            byte_t'($urandom));
            default: begin
              // on-screen target, reached through fold and wrap
              fold  = $urandom_range(0, 3);
              up    = $urandom_range(0, 15);
              row_v = byte_t'(fold - up);
              col_v = byte_t'((up << 4) | $urandom_range(0, 15));
              send_request(ACT_POS, byte_t'($urandom), row_v, col_v);
            end
          endcase
          run_to_idle(1'b1);
        end else if (kind < 85) begin
          send_request(ACT_POS, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
          run_to_idle(1'b1);
        end else if (kind < 95) begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            act = action_t'($urandom_range(0, 7));
            // keep power-up waits out of the random part
            if (act == ACT_INIT && pred_step == STEP_IDLE)
              act = ACT_NOP_FIRST;
            send_request(act, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
          end
          run_to_idle(1'b1);
        end else begin
          drain_results();
        end
      end
    end
  endtask

  // stimulus
  initial begin
    int waited;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_TICK;
    req_ch.value  <= '0;
    req_ch.row    <= '0;
    req_ch.col    <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    rst_n         <= 1'b0;
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_requests();
    test_eight_bit_init();
    test_byte_writes();
    test_set_position();
    test_four_bit_init();
    test_width_change();
    test_random_traffic();

    // wait out the last results
    req_ch.valid <= 1'b0;
    waited = 0;
    while (expected_pins.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $error("%0d expected results never arrived", expected_pins.size());
      error_count++;
    end

    $display("Sent %0d request transactions and checked %0d result transactions,",
             items_sent, results_checked);
    $display("on both bus widths with mid-sequence width changes; %0d were rejected.",
             rejects_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
sv/clws_pkg.sv
sv/clws_ifs.sv
sv/char_lcd_write_sequencer_top.sv
sim/char_lcd_write_sequencer_top_test.sv
